// ===== hdl/lomp_pkg.sv =====
`default_nettype none

package lomp_pkg;

    localparam int LINE_COUNT_W  = 13;
    localparam int LINE_W        = 12;
    localparam int OPCODE_W      = 3;
    localparam int TAG_PORT_W    = 32;
    localparam int DEF_MAX_LINES = 4096;
    localparam int DEF_TAG_BITS  = 32;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [OPCODE_W-1:0] OP_INIT  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_KEEP  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_DROP  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_ADD   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_NEXT  = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_SWEEP = 3'd5;

    typedef enum logic [2:0] {
        KIND_INIT,
        KIND_KEEP,
        KIND_DROP,
        KIND_ADD,
        KIND_NEXT,
        KIND_SWEEP
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [LINE_W-1:0]  line_index;
    } cmd_t;

    typedef struct packed {
        logic               clearing;
        logic               idle;
    } back_status_t;

    typedef struct packed {
        logic [OPCODE_W-1:0]   opcode;
        logic [LINE_W-1:0]     line_index;
        logic [TAG_PORT_W-1:0] commit_tag;
    } in_word_t;

    typedef struct packed {
        logic [LINE_W-1:0]     annotated_line;
        logic [TAG_PORT_W-1:0] origin_tag;
        logic                  all_done;
    } out_word_t;

endpackage

`default_nettype wire

// ===== hdl/lomp_front.sv =====
`default_nettype none

module lomp_front
    import lomp_pkg::*;
#(
    parameter int MAX_LINES = DEF_MAX_LINES,
    parameter int TAG_W     = DEF_TAG_BITS
)
(
    input  logic               start,
    output logic               busy,
    input  in_word_t           command,
    input  logic               q_full,
    input  back_status_t       status,
    output logic               push,
    output cmd_t               push_cmd,
    output logic [TAG_W-1:0]   push_tag
);

    logic keep_word;

    assign busy = q_full | status.clearing;

    always_comb
    begin
        keep_word           = 1'b1;
        push_cmd.kind       = KIND_INIT;
        push_cmd.line_index = command.line_index;
        case (command.opcode)
            OP_INIT:
            begin
                push_cmd.kind = KIND_INIT;
                keep_word     = 32'(command.line_index) < 32'(MAX_LINES);
            end
            OP_KEEP:  push_cmd.kind = KIND_KEEP;
            OP_DROP:  push_cmd.kind = KIND_DROP;
            OP_ADD:   push_cmd.kind = KIND_ADD;
            OP_NEXT:  push_cmd.kind = KIND_NEXT;
            OP_SWEEP: push_cmd.kind = KIND_SWEEP;
            default:  keep_word = 1'b0;
        endcase
    end

    assign push     = start & ~busy & keep_word;
    assign push_tag = TAG_W'(command.commit_tag);

endmodule

`default_nettype wire

// ===== hdl/lomp_queue.sv =====
`default_nettype none

module lomp_queue
    import lomp_pkg::*;
#(
    parameter int TAG_W = DEF_TAG_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cmd_t               push_cmd,
    input  logic [TAG_W-1:0]   push_tag,
    input  logic               pop,
    output logic               valid,
    output logic               full,
    output cmd_t               head_cmd,
    output logic [TAG_W-1:0]   head_tag
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t               cmd_mem [QUEUE_DEPTH];
    logic [TAG_W-1:0]   tag_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic               do_push, do_pop;

    assign valid    = level_reg != '0;
    assign full     = level_reg == LVL_W'(QUEUE_DEPTH);
    assign do_push  = push & ~full;
    assign do_pop   = pop & valid;
    assign head_cmd = cmd_mem[rd_ptr_reg];
    assign head_tag = tag_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            level_next = level_reg + 1'b1;
        else if (do_pop && !do_push)
            level_next = level_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cmd_mem[wr_ptr_reg] <= push_cmd;
            tag_mem[wr_ptr_reg] <= push_tag;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lomp_back.sv =====
`default_nettype none

module lomp_back
    import lomp_pkg::*;
#(
    parameter int MAX_LINES = DEF_MAX_LINES,
    parameter int TAG_W     = DEF_TAG_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [LINE_COUNT_W-1:0] line_count,
    input  logic                    q_valid,
    input  cmd_t                    q_cmd,
    input  logic [TAG_W-1:0]        q_tag,
    output logic                    q_pop,
    output back_status_t            status,
    output logic                    result_strobe,
    output out_word_t               result
);

    localparam int IDX_W     = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CNT_W     = $clog2(MAX_LINES + 1);
    localparam int CMP_W     = (CNT_W > LINE_COUNT_W) ? CNT_W : LINE_COUNT_W;
    localparam int MAP_DEPTH = 2 * MAX_LINES;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_MAP   = 4'b0100,
        ST_FLAG  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   old_idx_reg, old_idx_next;
    logic [CNT_W-1:0]   new_idx_reg, new_idx_next;
    logic               bank_reg, bank_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   clr_idx_reg, clr_idx_next;
    kind_t              kind_reg, kind_next;
    logic [CMP_W-1:0]   ln_reg, ln_next;
    logic               in_range_reg, in_range_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic               strobe_reg, strobe_next;
    logic [LINE_W-1:0]  out_line_reg, out_line_next;
    logic [TAG_W-1:0]   out_tag_reg, out_tag_next;
    logic               out_done_reg, out_done_next;

    logic [CNT_W-1:0]   map_mem [MAP_DEPTH];
    logic [CNT_W-1:0]   map_rdata_reg;
    logic               map_we, map_re;
    logic [MAP_AW-1:0]  map_waddr, map_raddr;
    logic [CNT_W-1:0]   map_wdata;

    logic               flag_mem [MAX_LINES];
    logic               flag_rdata_reg;
    logic               flag_we, flag_re, flag_wdata;
    logic [IDX_W-1:0]   flag_waddr, flag_raddr;

    logic [CMP_W-1:0]   eff_count;
    logic               all_ann, old_ok, new_ok;

    function automatic logic [MAP_AW-1:0] bank_addr(input logic bank,
                                                    input logic [CNT_W-1:0] idx);
        bank_addr = bank ? (MAP_AW'(MAX_LINES) + MAP_AW'(idx)) : MAP_AW'(idx);
    endfunction

    assign eff_count = (CMP_W'(line_count) < CMP_W'(MAX_LINES)) ?
                       CMP_W'(line_count) : CMP_W'(MAX_LINES);
    assign all_ann   = CMP_W'(count_reg) >= eff_count;
    assign old_ok    = old_idx_reg < CNT_W'(MAX_LINES);
    assign new_ok    = new_idx_reg < CNT_W'(MAX_LINES);

    always_comb
    begin
        state_next    = state_reg;
        old_idx_next  = old_idx_reg;
        new_idx_next  = new_idx_reg;
        bank_next     = bank_reg;
        count_next    = count_reg;
        clr_idx_next  = clr_idx_reg;
        kind_next     = kind_reg;
        ln_next       = ln_reg;
        in_range_next = in_range_reg;
        tag_next      = tag_reg;
        strobe_next   = 1'b0;
        out_line_next = out_line_reg;
        out_tag_next  = out_tag_reg;
        out_done_next = out_done_reg;
        q_pop         = 1'b0;
        map_we        = 1'b0;
        map_waddr     = '0;
        map_wdata     = '0;
        map_re        = 1'b0;
        map_raddr     = '0;
        flag_we       = 1'b0;
        flag_waddr    = ln_reg[IDX_W-1:0];
        flag_wdata    = 1'b0;
        flag_re       = 1'b0;
        flag_raddr    = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                flag_we      = 1'b1;
                flag_waddr   = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == IDX_W'(MAX_LINES - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    kind_next     = q_cmd.kind;
                    tag_next      = q_tag;
                    ln_next       = CMP_W'(q_cmd.line_index);
                    in_range_next = CMP_W'(q_cmd.line_index) < eff_count;
                    case (q_cmd.kind)
                        KIND_INIT:
                        begin
                            map_we     = 1'b1;
                            map_waddr  = bank_addr(bank_reg, CNT_W'(q_cmd.line_index));
                            map_wdata  = CNT_W'(q_cmd.line_index);
                            flag_re    = 1'b1;
                            flag_raddr = IDX_W'(q_cmd.line_index);
                            state_next = ST_FLAG;
                        end
                        KIND_KEEP:
                        begin
                            if (!all_ann && old_ok && new_ok)
                            begin
                                map_re     = 1'b1;
                                map_raddr  = bank_addr(bank_reg, new_idx_reg);
                                state_next = ST_MAP;
                            end
                        end
                        KIND_DROP:
                        begin
                            if (!all_ann && old_ok)
                            begin
                                map_we       = 1'b1;
                                map_waddr    = bank_addr(~bank_reg, old_idx_reg);
                                map_wdata    = '1;
                                old_idx_next = old_idx_reg + 1'b1;
                            end
                        end
                        KIND_ADD:
                        begin
                            if (!all_ann && new_ok)
                            begin
                                map_re       = 1'b1;
                                map_raddr    = bank_addr(bank_reg, new_idx_reg);
                                new_idx_next = new_idx_reg + 1'b1;
                                state_next   = ST_MAP;
                            end
                        end
                        KIND_NEXT:
                        begin
                            if (old_idx_reg != '0 || new_idx_reg != '0)
                                bank_next = ~bank_reg;
                            old_idx_next = '0;
                            new_idx_next = '0;
                        end
                        KIND_SWEEP:
                        begin
                            flag_re    = 1'b1;
                            flag_raddr = IDX_W'(q_cmd.line_index);
                            state_next = ST_FLAG;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MAP:
            begin
                if (kind_reg == KIND_KEEP)
                begin
                    map_we       = 1'b1;
                    map_waddr    = bank_addr(~bank_reg, old_idx_reg);
                    map_wdata    = map_rdata_reg;
                    old_idx_next = old_idx_reg + 1'b1;
                    new_idx_next = new_idx_reg + 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    ln_next       = CMP_W'(map_rdata_reg);
                    in_range_next = CMP_W'(map_rdata_reg) < eff_count;
                    flag_re       = 1'b1;
                    flag_raddr    = map_rdata_reg[IDX_W-1:0];
                    state_next    = ST_FLAG;
                end
            end
            ST_FLAG:
            begin
                if (kind_reg == KIND_INIT)
                begin
                    if (flag_rdata_reg)
                    begin
                        flag_we    = 1'b1;
                        flag_wdata = 1'b0;
                        if (count_reg != '0)
                            count_next = count_reg - 1'b1;
                    end
                end
                else if (in_range_reg && !flag_rdata_reg)
                begin
                    flag_we       = 1'b1;
                    flag_wdata    = 1'b1;
                    count_next    = count_reg + 1'b1;
                    strobe_next   = 1'b1;
                    out_line_next = ln_reg[LINE_W-1:0];
                    out_tag_next  = tag_reg;
                    out_done_next = (CMP_W'(count_reg) + CMP_W'(1)) >= eff_count;
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            old_idx_reg <= '0;
            new_idx_reg <= '0;
            bank_reg    <= 1'b0;
            count_reg   <= '0;
            clr_idx_reg <= '0;
            kind_reg    <= KIND_INIT;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            old_idx_reg <= old_idx_next;
            new_idx_reg <= new_idx_next;
            bank_reg    <= bank_next;
            count_reg   <= count_next;
            clr_idx_reg <= clr_idx_next;
            kind_reg    <= kind_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ln_reg       <= ln_next;
        in_range_reg <= in_range_next;
        tag_reg      <= tag_next;
        out_line_reg <= out_line_next;
        out_tag_reg  <= out_tag_next;
        out_done_reg <= out_done_next;
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_waddr] <= map_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (map_re)
            map_rdata_reg <= map_mem[map_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (flag_we)
            flag_mem[flag_waddr] <= flag_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (flag_re)
            flag_rdata_reg <= flag_mem[flag_raddr];
    end

    assign status.clearing       = state_reg == ST_CLEAR;
    assign status.idle           = state_reg == ST_IDLE;
    assign result_strobe         = strobe_reg;
    assign result.annotated_line = out_line_reg;
    assign result.origin_tag     = TAG_PORT_W'(out_tag_reg);
    assign result.all_done       = out_done_reg;

endmodule

`default_nettype wire

// ===== hdl/line_origin_map_propagator.sv =====
// Back end steps per word: drop and next finish in idle; keep passes through ST_MAP,
// init and sweep through ST_FLAG, and add through ST_MAP, then ST_FLAG
// (map memory read, then annotated-flag memory read, each with registered data).
// A two-word queue between front and back lets start be taken while the back end works.
// Reset: indices, bank select and count clear at once; the flag memory is then swept
// clear, all MAX_LINES entries, with busy high; map entries are undefined until written.
`default_nettype none

module line_origin_map_propagator
    import lomp_pkg::*;
#(
    parameter int MAX_LINES = DEF_MAX_LINES,
    parameter int TAG_BITS  = DEF_TAG_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  in_word_t                command,
    output logic                    result_strobe,
    output out_word_t               result,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [LINE_COUNT_W-1:0] cfg_data
);

    localparam int TAG_W = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;

    logic [LINE_COUNT_W-1:0] line_count_reg;
    logic                    q_push, q_pop, q_valid, q_full;
    cmd_t                    push_cmd, head_cmd;
    logic [TAG_W-1:0]        push_tag, head_tag;
    back_status_t            status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_count_reg <= '0;
        else if (cfg_valid && cfg_ready)
            line_count_reg <= cfg_data;
    end

    lomp_front #(
        .MAX_LINES (MAX_LINES),
        .TAG_W     (TAG_W)
    ) u_front (
        .start    (start),
        .busy     (busy),
        .command  (command),
        .q_full   (q_full),
        .status   (status),
        .push     (q_push),
        .push_cmd (push_cmd),
        .push_tag (push_tag)
    );

    lomp_queue #(
        .TAG_W (TAG_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .push_tag (push_tag),
        .pop      (q_pop),
        .valid    (q_valid),
        .full     (q_full),
        .head_cmd (head_cmd),
        .head_tag (head_tag)
    );

    lomp_back #(
        .MAX_LINES (MAX_LINES),
        .TAG_W     (TAG_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .line_count    (line_count_reg),
        .q_valid       (q_valid),
        .q_cmd         (head_cmd),
        .q_tag         (head_tag),
        .q_pop         (q_pop),
        .status        (status),
        .result_strobe (result_strobe),
        .result        (result)
    );

    a_busy_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> busy)
        else $error("word could be taken during flag clearing");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_pop_only_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (status.idle && q_valid))
        else $error("queue pop outside idle");

    a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |=> !result_strobe)
        else $error("back-to-back results");

endmodule

`default_nettype wire

// ===== tb/sv/origin_annotation_checker.sv =====
module origin_annotation_checker
    import lomp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  in_word_t                command,
    input  logic                    result_strobe,
    input  out_word_t               result,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [LINE_COUNT_W-1:0] cfg_data,
    output int unsigned             mismatches,
    output int unsigned             outstanding
);

    localparam int DEPTH = DEF_MAX_LINES;
    localparam logic [LINE_COUNT_W-1:0] NO_LINE = '1;

    logic [LINE_COUNT_W-1:0] map_a [DEPTH];
    logic [LINE_COUNT_W-1:0] map_b [DEPTH];
    bit                      line_flag [DEPTH];
    logic [LINE_COUNT_W-1:0] lines_total;
    int                      lines_done;
    int                      wr_pos;
    int                      rd_pos;
    bit                      rd_is_b;
    int unsigned             fail_count;
    out_word_t               expected_annotations [$];

    function automatic int lines_in_file();
        return (lines_total > DEPTH) ? DEPTH : int'(lines_total);
    endfunction

    function automatic bit file_complete();
        return lines_done >= lines_in_file();
    endfunction

    function automatic logic [LINE_COUNT_W-1:0] read_map(input int pos);
        return rd_is_b ? map_b[pos] : map_a[pos];
    endfunction

    task automatic write_map(input int pos, input logic [LINE_COUNT_W-1:0] val);
        if (rd_is_b)
            map_a[pos] = val;
        else
            map_b[pos] = val;
    endtask

    task automatic mark_origin(input logic [LINE_COUNT_W-1:0] ln, input logic [31:0] tag);
        out_word_t w;
        if (ln < lines_in_file() && !line_flag[ln[LINE_W-1:0]])
        begin
            line_flag[ln[LINE_W-1:0]] = 1'b1;
            lines_done++;
            w.annotated_line = ln[LINE_W-1:0];
            w.origin_tag     = tag;
            w.all_done       = file_complete();
            expected_annotations.push_back(w);
        end
    endtask

    task automatic propagate_edit(input in_word_t w);
        int li;
        li = int'(w.line_index);
        case (w.opcode)
            OP_INIT:
            begin
                if (rd_is_b)
                    map_b[li] = LINE_COUNT_W'(li);
                else
                    map_a[li] = LINE_COUNT_W'(li);
                if (line_flag[li])
                begin
                    line_flag[li] = 1'b0;
                    if (lines_done > 0)
                        lines_done--;
                end
            end
            OP_KEEP:
            begin
                if (!file_complete() && wr_pos < DEPTH && rd_pos < DEPTH)
                begin
                    write_map(wr_pos, read_map(rd_pos));
                    wr_pos++;
                    rd_pos++;
                end
            end
            OP_DROP:
            begin
                if (!file_complete() && wr_pos < DEPTH)
                begin
                    write_map(wr_pos, NO_LINE);
                    wr_pos++;
                end
            end
            OP_ADD:
            begin
                if (!file_complete() && rd_pos < DEPTH)
                begin
                    rd_pos++;
                    mark_origin(read_map(rd_pos - 1), w.commit_tag);
                end
            end
            OP_NEXT:
            begin
                // empty commit keeps the map as it is
                if (wr_pos != 0 || rd_pos != 0)
                    rd_is_b = !rd_is_b;
                wr_pos = 0;
                rd_pos = 0;
            end
            OP_SWEEP:
                mark_origin(LINE_COUNT_W'(li), w.commit_tag);
            default:
                ;
        endcase
    endtask

    task automatic check_annotation(input out_word_t got);
        out_word_t want;
        if (expected_annotations.size() == 0)
        begin
            $display("%0t: unexpected word: expected none, actual line %0d tag %h done %0b",
                     $time, got.annotated_line, got.origin_tag, got.all_done);
            fail_count++;
        end
        else
        begin
            want = expected_annotations.pop_front();
            if (got.annotated_line !== want.annotated_line)
            begin
                $display("%0t: annotated_line expected %0d actual %0d",
                         $time, want.annotated_line, got.annotated_line);
                fail_count++;
            end
            if (got.origin_tag !== want.origin_tag)
            begin
                $display("%0t: origin_tag expected %h actual %h",
                         $time, want.origin_tag, got.origin_tag);
                fail_count++;
            end
            if (got.all_done !== want.all_done)
            begin
                $display("%0t: all_done expected %0b actual %0b",
                         $time, want.all_done, got.all_done);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                line_flag[i] = 1'b0;
            lines_total = '0;
            lines_done  = 0;
            wr_pos      = 0;
            rd_pos      = 0;
            rd_is_b     = 1'b0;
            fail_count  = 0;
            expected_annotations.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_strobe)
                check_annotation(result);
            if (cfg_valid && cfg_ready)
                lines_total = cfg_data;
            if (start && !busy)
                propagate_edit(command);
            mismatches  <= fail_count;
            outstanding <= expected_annotations.size();
        end
    end

endmodule

// ===== tb/sv/tb_line_origin_map_propagator.sv =====
module tb_line_origin_map_propagator;
    import lomp_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 16;
    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;
    localparam logic [LINE_COUNT_W-1:0] COUNT_ALL_ONES = '1;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    in_word_t                command;
    logic                    result_strobe;
    out_word_t               result;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [LINE_COUNT_W-1:0] cfg_data;
    int unsigned             mismatches;
    int unsigned             outstanding;

    int stall_cycles;
    int gap_chance;
    int rd_len;
    int new_pos;
    int old_pos;
    int dirty_hi;
    int file_edits;

    line_origin_map_propagator dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .result_strobe (result_strobe),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    origin_annotation_checker annotation_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .result_strobe (result_strobe),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic in_word_t make_edit(input logic [OPCODE_W-1:0] op, input int li,
                                           input logic [31:0] tag);
        in_word_t w;
        w.opcode     = op;
        w.line_index = li[LINE_W-1:0];
        w.commit_tag = tag;
        return w;
    endfunction

    task automatic send_edit(input in_word_t w);
        if (gap_chance != 0 && $urandom_range(1, 100) <= gap_chance)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        start   <= 1'b1;
        command <= w;
        do
            @(posedge clk);
        while (busy);
        file_edits++;
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_line_count(input logic [LINE_COUNT_W-1:0] n);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // clears every flag that may be set and loads the identity map for the opened lines
    task automatic open_file(input int opened);
        int n;
        int span;
        span = (opened > dirty_hi) ? opened : dirty_hi;
        send_edit(make_edit(OP_NEXT, 0, $urandom));
        for (n = 0; n < span; n++)
            send_edit(make_edit(OP_INIT, n, $urandom));
        dirty_hi = opened;
        rd_len   = opened;
        new_pos  = 0;
        old_pos  = 0;
    endtask

    // lines in [0, opened) or beyond the count only, so the file never completes early
    task automatic run_file(input int count_reg, input int opened, input int n_edits,
                            input bit close_all, input int gap_pct);
        int              lines_eff;
        int              n;
        int              pick;
        int              li;
        logic [2:0]      op;
        logic [31:0]     tag;
        lines_eff  = (count_reg > DEF_MAX_LINES) ? DEF_MAX_LINES : count_reg;
        gap_chance = gap_pct;
        write_line_count(count_reg[LINE_COUNT_W-1:0]);
        open_file(opened);
        tag = $urandom;
        for (n = 0; n < n_edits; n++)
        begin
            li = $urandom_range(0, 4095);
            if (lines_eff == 0)
            begin
                // nothing moves here, so any word is safe
                op = 3'($urandom_range(0, 7));
                send_edit(make_edit(op, li, $urandom));
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    op = OP_NEXT;
                else if (pick < 30)
                    op = OP_KEEP;
                else if (pick < 45)
                    op = OP_DROP;
                else if (pick < 75)
                    op = OP_ADD;
                else if (pick < 88)
                    op = OP_SWEEP;
                else if (pick < 94)
                    op = OP_INIT;
                else
                    op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
                if ((op == OP_KEEP || op == OP_ADD) && new_pos >= rd_len)
                    op = OP_DROP;
                if (op == OP_INIT)
                begin
                    if (opened > 0)
                        li = $urandom_range(0, opened - 1);
                    else
                        op = OP_SPARE_LO;
                end
                if (op == OP_SWEEP)
                begin
                    if (opened > 0 && (lines_eff == DEF_MAX_LINES || $urandom_range(0, 1)))
                        li = $urandom_range(0, opened - 1);
                    else if (lines_eff < DEF_MAX_LINES)
                        li = $urandom_range(lines_eff, 4095);
                    else
                        op = OP_DROP;
                end
                send_edit(make_edit(op, li, ($urandom_range(0, 7) == 0) ? $urandom : tag));
                case (op)
                    OP_KEEP:
                    begin
                        new_pos++;
                        old_pos++;
                    end
                    OP_DROP:
                        old_pos++;
                    OP_ADD:
                        new_pos++;
                    OP_NEXT:
                    begin
                        if (new_pos != 0 || old_pos != 0)
                            rd_len = old_pos;
                        new_pos = 0;
                        old_pos = 0;
                        tag     = $urandom;
                    end
                    default:
                        ;
                endcase
            end
        end
        if (close_all && lines_eff > 0)
        begin
            for (n = 0; n < lines_eff; n++)
                send_edit(make_edit(OP_SWEEP, n, tag));
            // all annotated: map edits are dropped
            send_edit(make_edit(OP_KEEP, 0, tag));
            send_edit(make_edit(OP_ADD, 0, tag));
            send_edit(make_edit(OP_DROP, 0, tag));
            li = $urandom_range(0, lines_eff - 1);
            send_edit(make_edit(OP_INIT, li, tag));
            send_edit(make_edit(OP_SWEEP, li, $urandom));
            dirty_hi = lines_eff;
        end
    endtask

    initial
    begin
        int ep;
        int gap;
        int opened;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        command    <= '0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        gap_chance = 10;
        rd_len     = 0;
        new_pos    = 0;
        old_pos    = 0;
        dirty_hi   = 0;
        file_edits = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // line count zero after reset: everything but init does nothing
        send_edit(make_edit(OP_NEXT, 0, 32'h0));
        send_edit(make_edit(OP_KEEP, 0, 32'h0));
        send_edit(make_edit(OP_DROP, 0, 32'h0));
        send_edit(make_edit(OP_ADD, 0, 32'hffff_ffff));
        send_edit(make_edit(OP_SWEEP, 0, 32'hffff_ffff));
        send_edit(make_edit(OP_SPARE_LO, 4095, 32'hffff_ffff));
        send_edit(make_edit(OP_SPARE_HI, 0, 32'h0));
        send_edit(make_edit(OP_INIT, 4095, 32'h0));
        write_line_count(COUNT_ALL_ONES);
        send_edit(make_edit(OP_SWEEP, 4095, 32'hffff_ffff));
        send_edit(make_edit(OP_SWEEP, 0, 32'h0));
        send_edit(make_edit(OP_SWEEP, 4095, 32'h1234_5678));
        send_edit(make_edit(OP_INIT, 4095, 32'h0));
        send_edit(make_edit(OP_SWEEP, 4095, 32'ha5a5_a5a5));
        send_edit(make_edit(OP_INIT, 0, 32'h0));
        send_edit(make_edit(OP_ADD, 0, 32'h5a5a_5a5a));
        send_edit(make_edit(OP_DROP, 0, 32'h0));
        send_edit(make_edit(OP_NEXT, 0, 32'h0));
        send_edit(make_edit(OP_ADD, 0, 32'hffff_ffff));
        send_edit(make_edit(OP_INIT, 0, 32'h0));
        send_edit(make_edit(OP_INIT, 4095, 32'h0));

        ep = 0;
        while (file_edits < 1060)
        begin
            gap = (file_edits > 950) ? 0 : 10 * $urandom_range(0, 3);
            opened = $urandom_range(0, 24);
            case (ep)
                1: run_file(0, 4, 30, 1'b0, gap);
                2: run_file(4096, 20, 60, 1'b0, gap);
                4: run_file(1, 0, 20, 1'b1, gap);
                6: run_file(8191, 16, 50, 1'b0, gap);
                default:
                    run_file(opened + $urandom_range(1, 8), opened, $urandom_range(20, 70),
                             $urandom_range(0, 2) != 0, gap);
            endcase
            ep++;
        end
        drain();

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
